// ===== hw/rtl/ple_pkg.sv =====
// Shared constants, codes and types for the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

	// List size and the widths that follow from it.
	localparam int CAPACITY = 32;
	localparam int LEN_W    = $clog2(CAPACITY + 1);
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CMP_W    = ((LEN_W > 6) ? LEN_W : 6) + 1;
	localparam int DATA_W   = 32;

	// Input field widths.
	localparam int CMD_W   = 2;
	localparam int COUNT_W = 6;
	localparam int POS_W   = 6;
	localparam int IN_W    = 48;

	// Command codes.
	localparam logic [CMD_W-1:0] CMD_CREATE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;
	localparam logic [CMD_W-1:0] CMD_PRINT  = 2'd3;

	// Status codes.
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_CLAMPED = 2'd2;
	localparam logic [1:0] ST_ABSENT  = 2'd3;

	// Cell chain operations.
	localparam logic [2:0] OP_HOLD = 3'd0;
	localparam logic [2:0] OP_FILL = 3'd1;
	localparam logic [2:0] OP_INS  = 3'd2;
	localparam logic [2:0] OP_DEL  = 3'd3;
	localparam logic [2:0] OP_ROT  = 3'd4;

	// Control broadcast to every cell of the chain.
	typedef struct packed {
		logic [2:0]        op;
		logic [LEN_W-1:0]  pos;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] value;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/ple_cell.sv =====
// One storage cell of the list chain, shifting with its neighbors.
`timescale 1ns / 1ps

module ple_cell
	import ple_pkg::*;
(
	input  logic              clk,
	input  logic [IDX_W-1:0]  index,
	input  cell_ctl_t         ctl,
	input  logic [DATA_W-1:0] left_data,
	input  logic [DATA_W-1:0] right_data,
	input  logic [DATA_W-1:0] head_data,
	output logic [DATA_W-1:0] data
);

	logic [DATA_W-1:0] data_q;
	logic [LEN_W:0]    ix;
	logic [LEN_W:0]    ix_next;
	logic [LEN_W:0]    pos_x;
	logic [LEN_W:0]    len_x;

	assign ix      = (LEN_W + 1)'(index);
	assign ix_next = ix + 1'b1;
	assign pos_x   = {1'b0, ctl.pos};
	assign len_x   = {1'b0, ctl.len};
	assign data    = data_q;

	// Each cell decides from its own place which neighbor to take.
	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_FILL: begin
				if (ix < len_x) begin
					data_q <= DATA_W'(index) + 1'b1;
				end
			end
			OP_INS: begin
				if (ix == pos_x) begin
					data_q <= ctl.value;
				end else if (ix > pos_x && ix <= len_x) begin
					data_q <= left_data;
				end
			end
			OP_DEL: begin
				if (ix >= pos_x && ix_next < len_x) begin
					data_q <= right_data;
				end
			end
			OP_ROT: begin
				if (ix_next < len_x) begin
					data_q <= right_data;
				end else if (ix_next == len_x) begin
					data_q <= head_data;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: command decode, print sequencer and cell chain.
// Create, insert and delete update the cell chain on acceptance; their status word is
// presented in the cycle after the command is accepted.
// Print of n elements rotates the chain once per output word, each rotation waiting for the
// output register to be free; the next command waits until the last word is registered.
// A command is taken only when the output register is free or drains in that cycle.
// Reset (arst_n low, asynchronous) empties the list; cell contents are not cleared.
`timescale 1ns / 1ps

module positional_list_engine
	import ple_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // count[5:0], position[11:6], value[43:12], zero pad
	input  logic [CMD_W-1:0] s_tuser,   // command[1:0]
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [DATA_W-1:0] m_tdata,  // item_value[31:0]
	output logic [3:0]       m_tuser,   // is_element[0], list_empty[1], status[3:2]
	output logic             m_tlast
);

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_PRINT = 1'b1;

	logic              state_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  remain_q;
	logic              m_tvalid_q;
	logic [DATA_W-1:0] m_tdata_q;
	logic [3:0]        m_tuser_q;
	logic              m_tlast_q;

	logic [CMD_W-1:0]   cmd;
	logic [COUNT_W-1:0] count;
	logic [POS_W-1:0]   position;
	logic [DATA_W-1:0]  value;
	logic [POS_W-1:0]   idx;
	logic [CMP_W-1:0]   idx_w;
	logic [CMP_W-1:0]   len_w;
	logic [CMP_W-1:0]   cnt_w;
	logic               out_free;
	logic               accept;
	logic               full;
	logic               word_load;

	cell_ctl_t         ctl;
	logic [DATA_W-1:0] cell_data [CAPACITY];

	// Input word unpacking.
	assign cmd      = s_tuser;
	assign count    = s_tdata[5:0];
	assign position = s_tdata[11:6];
	assign value    = s_tdata[43:12];
	assign idx      = (position == '0) ? '0 : position - 1'b1;
	assign idx_w    = CMP_W'(idx);
	assign len_w    = CMP_W'(length_q);
	assign cnt_w    = CMP_W'(count);
	assign full     = (length_q == LEN_W'(CAPACITY));

	// Handshake.
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	// A word enters the output register on every print step and on every
	// accepted command except a print of a non-empty list.
	assign word_load = ((state_q == ST_PRINT) && out_free)
		|| (accept && ((cmd != CMD_PRINT) || (length_q == '0)));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
	assign m_tlast  = m_tlast_q;

	// Chain control for the current cycle.
	always_comb begin
		ctl.op    = OP_HOLD;
		ctl.pos   = '0;
		ctl.len   = length_q;
		ctl.value = value;
		if (state_q == ST_PRINT) begin
			if (out_free) begin
				ctl.op = OP_ROT;
			end
		end else if (accept) begin
			case (cmd)
				CMD_CREATE: begin
					ctl.op  = OP_FILL;
					ctl.len = (cnt_w > CMP_W'(CAPACITY)) ? LEN_W'(CAPACITY) : LEN_W'(count);
				end
				CMD_INSERT: begin
					if (!full) begin
						ctl.op  = OP_INS;
						ctl.pos = (idx_w > len_w) ? length_q : LEN_W'(idx);
					end
				end
				CMD_DELETE: begin
					if (idx_w < len_w) begin
						ctl.op  = OP_DEL;
						ctl.pos = LEN_W'(idx);
					end
				end
				default: begin
					ctl.op = OP_HOLD;
				end
			endcase
		end
	end

	// The chain of cells.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		ple_cell u_cell (
			.clk        (clk),
			.index      (IDX_W'(i)),
			.ctl        (ctl),
			.left_data  ((i == 0) ? '0 : cell_data[(i == 0) ? 0 : i - 1]),
			.right_data ((i == CAPACITY - 1) ? '0 : cell_data[(i == CAPACITY - 1) ? i : i + 1]),
			.head_data  (cell_data[0]),
			.data       (cell_data[i])
		);
	end

	// Sequencer, list length and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			length_q   <= '0;
			remain_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (word_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (state_q == ST_PRINT) begin
				if (out_free) begin
					remain_q <= remain_q - 1'b1;
					if (remain_q == LEN_W'(1)) begin
						state_q <= ST_IDLE;
					end
				end
			end else if (accept) begin
				case (cmd)
					CMD_CREATE: begin
						length_q <= ctl.len;
					end
					CMD_INSERT: begin
						if (!full) begin
							length_q <= length_q + 1'b1;
						end
					end
					CMD_DELETE: begin
						if (idx_w < len_w) begin
							length_q <= length_q - 1'b1;
						end
					end
					default: begin
						if (length_q != '0) begin
							state_q  <= ST_PRINT;
							remain_q <= length_q;
						end
					end
				endcase
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (state_q == ST_PRINT) begin
			if (out_free) begin
				m_tdata_q <= cell_data[0];
				m_tuser_q <= {ST_OK, 1'b0, 1'b1};
				m_tlast_q <= (remain_q == LEN_W'(1));
			end
		end else if (accept) begin
			m_tdata_q <= '0;
			m_tlast_q <= 1'b1;
			case (cmd)
				CMD_CREATE: begin
					m_tuser_q <= {(cnt_w > CMP_W'(CAPACITY)) ? ST_CLAMPED : ST_OK, 2'b00};
				end
				CMD_INSERT: begin
					m_tuser_q <= {full ? ST_FULL : ST_OK, 2'b00};
				end
				CMD_DELETE: begin
					m_tuser_q <= {(idx_w < len_w) ? ST_OK : ST_ABSENT, 2'b00};
				end
				default: begin
					m_tuser_q <= {ST_OK, 1'b1, 1'b0};
				end
			endcase
		end
	end

	// Checks on the list bookkeeping.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		length_q <= LEN_W'(CAPACITY))
		else $error("list length beyond capacity");

	a_print_remain: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRINT |-> remain_q != '0 && remain_q <= length_q)
		else $error("print count out of range");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_INSERT && !full |=> length_q == LEN_W'($past(length_q) + 1'b1))
		else $error("insert did not grow the list");

	a_print_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept && cmd == CMD_PRINT && length_q != '0 |=> state_q == ST_PRINT && !s_tready)
		else $error("print did not start");

	a_print_len_kept: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PRINT |=> length_q == $past(length_q))
		else $error("length changed during print");

endmodule

// ===== test/ple_list_checker.sv =====
// Checker for the positional list engine: mirrors the list and compares every output word.
`timescale 1ns / 1ps

module ple_list_checker
	import ple_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [IN_W-1:0]   s_tdata,   // count[5:0], position[11:6], value[43:12], zero pad
	input  logic [CMD_W-1:0]  s_tuser,   // command[1:0]
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [DATA_W-1:0] m_tdata,   // item_value[31:0]
	input  logic [3:0]        m_tuser,   // is_element[0], list_empty[1], status[3:2]
	input  logic              m_tlast,
	output int                mismatches,
	output int                outstanding
);

	// One output word as the engine should present it.
	typedef struct packed {
		logic [DATA_W-1:0] item_value;
		logic              is_element;
		logic              list_empty;
		logic [1:0]        status;
		logic              last;
	} list_word_t;

	// Mirror of the list held by the engine.
	logic [DATA_W-1:0] mirror_cells [CAPACITY];
	int unsigned       mirror_len;

	// Words still owed by the engine, oldest first.
	list_word_t due_words [$];

	function automatic list_word_t status_word(input logic [1:0] code);
		list_word_t w;
		w = '0;
		w.status = code;
		w.last   = 1'b1;
		return w;
	endfunction

	// Append one word at the tail of the owed list.
	function automatic void owe_word(input list_word_t w);
		due_words.insert(due_words.size(), w);
	endfunction

	// Apply one accepted command to the mirror and queue the words it causes.
	task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] cnt,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val);
		int unsigned idx;
		int unsigned n;
		list_word_t  w;
		idx = (pos == 0) ? 0 : pos - 1;
		case (cmd)
			CMD_CREATE: begin
				n = 32'(cnt);
				if (n > CAPACITY) begin
					n = CAPACITY;
					owe_word(status_word(ST_CLAMPED));
				end else begin
					owe_word(status_word(ST_OK));
				end
				for (int i = 0; i < n; i++)
					mirror_cells[i] = i + 1;
				mirror_len = n;
			end
			CMD_INSERT: begin
				if (mirror_len >= CAPACITY) begin
					owe_word(status_word(ST_FULL));
				end else begin
					if (idx > mirror_len)
						idx = mirror_len;
					for (int i = mirror_len; i > idx; i--)
						mirror_cells[i] = mirror_cells[i-1];
					mirror_cells[idx] = val;
					mirror_len++;
					owe_word(status_word(ST_OK));
				end
			end
			CMD_DELETE: begin
				if (idx >= mirror_len) begin
					owe_word(status_word(ST_ABSENT));
				end else begin
					for (int i = idx; i + 1 < mirror_len; i++)
						mirror_cells[i] = mirror_cells[i+1];
					mirror_len--;
					owe_word(status_word(ST_OK));
				end
			end
			default: begin
				// Print: one word per element, or a single empty marker.
				if (mirror_len == 0) begin
					w = status_word(ST_OK);
					w.list_empty = 1'b1;
					owe_word(w);
				end else begin
					for (int i = 0; i < mirror_len; i++) begin
						w = '0;
						w.item_value = mirror_cells[i];
						w.is_element = 1'b1;
						w.status     = ST_OK;
						w.last       = (i + 1 == mirror_len);
						owe_word(w);
					end
				end
			end
		endcase
	endtask

	task automatic note_mismatch(input string what, input list_word_t want, input list_word_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t mismatch (%s): expected value=%h elem=%b empty=%b status=%0d last=%b",
				$realtime, what, want.item_value, want.is_element, want.list_empty,
				want.status, want.last);
			$display("%0t mismatch (%s): got      value=%h elem=%b empty=%b status=%0d last=%b",
				$realtime, what, got.item_value, got.is_element, got.list_empty,
				got.status, got.last);
		end
	endtask

	// Sample both channels at each edge; inputs are predicted before outputs are checked.
	always @(posedge clk or negedge arst_n) begin : watch
		list_word_t got;
		list_word_t want;
		if (!arst_n) begin
			mirror_len = 0;
			mismatches = 0;
			due_words.delete();
		end else begin
			if (s_tvalid && s_tready)
				apply_command(s_tuser, s_tdata[5:0], s_tdata[11:6], s_tdata[43:12]);
			if (m_tvalid && m_tready) begin
				got.item_value = m_tdata;
				got.is_element = m_tuser[0];
				got.list_empty = m_tuser[1];
				got.status     = m_tuser[3:2];
				got.last       = m_tlast;
				if (due_words.size() == 0) begin
					note_mismatch("unexpected word", '0, got);
				end else begin
					want = due_words.pop_front();
					if (got.item_value !== want.item_value)
						note_mismatch("item_value", want, got);
					else if (got.is_element !== want.is_element)
						note_mismatch("is_element", want, got);
					else if (got.list_empty !== want.list_empty)
						note_mismatch("list_empty", want, got);
					else if (got.status !== want.status)
						note_mismatch("status", want, got);
					else if (got.last !== want.last)
						note_mismatch("last", want, got);
				end
			end
		end
		outstanding <= due_words.size();
	end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the positional list engine: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
	import ple_pkg::*;
();

	localparam int RANDOM_ITEMS = 208;
	localparam int LONG_HOLD    = 400;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata;    // count[5:0], position[11:6], value[43:12], zero pad
	logic [CMD_W-1:0]  s_tuser;    // command[1:0]
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;    // item_value[31:0]
	logic [3:0]        m_tuser;    // is_element[0], list_empty[1], status[3:2]
	logic              m_tlast;
	int                mismatches;
	int                outstanding;

	// Requests for a long receiver hold-off, and how many the receiver has served.
	int hold_requests = 0;
	int holds_served  = 0;

	positional_list_engine dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	ple_list_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit far above the slowest correct run.
	initial begin
		#10000000;
		$display("positional_list_engine regression: fail");
		$finish;
	end

	// Idle length: mostly none or short, a few long.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		else if (r < 88)
			return $urandom_range(1, 3);
		else if (r < 97)
			return $urandom_range(4, 12);
		else
			return $urandom_range(20, 60);
	endfunction

	// Receiver: random ready pattern, with a long hold-off whenever one is requested.
	initial begin : receiver
		int r;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (holds_served != hold_requests) begin
				holds_served++;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else begin
				r = $urandom_range(0, 99);
				if (r < 65) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(1, 8)) @(posedge clk);
				end else if (r < 70) begin
					m_tready <= 1'b1;
					repeat ($urandom_range(40, 80)) @(posedge clk);
				end else begin
					m_tready <= 1'b0;
					repeat (pick_gap() + 1) @(posedge clk);
				end
			end
		end
	end

	// Offer one command word after an idle gap and hold it until it is accepted.
	task automatic issue_cmd(input logic [CMD_W-1:0] cmd, input logic [COUNT_W-1:0] cnt,
			input logic [POS_W-1:0] pos, input logic [DATA_W-1:0] val, input int gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {4'b0, val, pos, cnt};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop offering until the engine has delivered every word it owes.
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Stimulus: directed corner cases, then weighted random commands.
	initial begin : stimulus
		int               r;
		bit               quiet;
		logic [CMD_W-1:0] cmd;
		logic [5:0]       cnt;
		logic [5:0]       pos;
		logic [31:0]      val;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = CMD_CREATE;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Empty list: print, then delete at position zero.
		issue_cmd(CMD_PRINT, 6'd63, 6'd63, 32'hFFFF_FFFF, pick_gap());
		issue_cmd(CMD_DELETE, 6'd0, 6'd0, 32'h0, pick_gap());
		// Inserts at the front, beyond the end and in the middle.
		issue_cmd(CMD_INSERT, 6'd0, 6'd0, 32'h8000_0000, pick_gap());
		issue_cmd(CMD_INSERT, 6'd63, 6'd63, 32'h7FFF_FFFF, pick_gap());
		issue_cmd(CMD_INSERT, 6'd0, 6'd1, 32'hFFFF_FFFF, pick_gap());
		issue_cmd(CMD_INSERT, 6'd0, 6'd2, 32'h0, pick_gap());
		issue_cmd(CMD_PRINT, 6'd0, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_DELETE, 6'd0, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_DELETE, 6'd0, 6'd63, 32'h0, pick_gap());
		// Create of zero empties the list.
		issue_cmd(CMD_CREATE, 6'd0, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_PRINT, 6'd0, 6'd0, 32'h0, pick_gap());
		// Oversized create clamps; the full list then drops an insert.
		issue_cmd(CMD_CREATE, 6'd63, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_INSERT, 6'd0, 6'd5, 32'hDEAD_BEEF, pick_gap());
		issue_cmd(CMD_PRINT, 6'd0, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_DELETE, 6'd0, 6'd32, 32'h0, pick_gap());
		issue_cmd(CMD_INSERT, 6'd0, 6'd32, 32'h5555_AAAA, pick_gap());
		issue_cmd(CMD_DELETE, 6'd0, 6'd33, 32'h0, pick_gap());
		issue_cmd(CMD_PRINT, 6'd0, 6'd0, 32'h0, pick_gap());
		// Create exactly at capacity and one past it.
		issue_cmd(CMD_CREATE, 6'd32, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_CREATE, 6'd33, 6'd0, 32'h0, pick_gap());
		// Single element removed, then a short list with a middle insert.
		issue_cmd(CMD_CREATE, 6'd1, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_DELETE, 6'd0, 6'd1, 32'h0, pick_gap());
		issue_cmd(CMD_PRINT, 6'd0, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_CREATE, 6'd5, 6'd0, 32'h0, pick_gap());
		issue_cmd(CMD_INSERT, 6'd0, 6'd3, 32'h1234_5678, pick_gap());
		drain_results();

		// Random commands; fields a command does not use carry noise.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 50 || n == 150)
				hold_requests++;
			if (n == 100 || n == 180)
				drain_results();
			quiet = (n % 60) >= 45;
			r = $urandom_range(0, 99);
			if (r < 10)
				cmd = CMD_CREATE;
			else if (r < 50)
				cmd = CMD_INSERT;
			else if (r < 78)
				cmd = CMD_DELETE;
			else
				cmd = CMD_PRINT;
			r = $urandom_range(0, 99);
			if (cmd != CMD_CREATE)
				cnt = 6'($urandom_range(0, 63));
			else if (r < 60)
				cnt = 6'($urandom_range(0, 12));
			else if (r < 90)
				cnt = 6'($urandom_range(25, 40));
			else
				cnt = 6'd63;
			pos = ($urandom_range(0, 99) < 80) ? 6'($urandom_range(0, 34))
				: 6'($urandom_range(0, 63));
			r = $urandom_range(0, 99);
			if (r < 8)
				val = 32'h8000_0000;
			else if (r < 16)
				val = 32'h7FFF_FFFF;
			else if (r < 20)
				val = 32'h0;
			else if (r < 24)
				val = 32'hFFFF_FFFF;
			else
				val = $urandom();
			issue_cmd(cmd, cnt, pos, val, quiet ? 0 : pick_gap());
		end
		drain_results();
		repeat (40) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("positional_list_engine regression: pass");
		else
			$display("positional_list_engine regression: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine.sv
test/ple_list_checker.sv
test/tb_top.sv
